[sv/simplex_noise_4d_top_defines.svh]
`ifndef SIMPLEX_NOISE_4D_TOP_DEFINES_SVH
`define SIMPLEX_NOISE_4D_TOP_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define SND4_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pipeline check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define SND4_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pipeline check failed");

`endif

[sv/snd4_pkg.sv]
package snd4_pkg;

	localparam int NAXIS   = 4;
	localparam int NCORNER = 5;

	// Offset and corner vector widths, Q24.
	localparam int DW   = 30;
	localparam int VW   = 31;
	localparam int SQW  = 2 * VW;
	localparam int R2W  = SQW + 2;
	localparam int FW   = 24;
	localparam int FLW  = R2W - FW + 2;
	localparam int DOTW = VW + 2;
	localparam int TW   = FW + 1 + DOTW;
	localparam int ACW  = TW + 3;
	localparam int SCW  = ACW + 5;
	localparam int NW   = 16;

	localparam int LAT_STAGES    = 7;
	localparam int CORNER_STAGES = 6;
	localparam int DEPTH         = LAT_STAGES + CORNER_STAGES + 1;

	localparam logic signed [27:0] F4_Q28 = 28'sd82951118;
	localparam logic signed [30:0] G4_Q32 = 31'sd593549882;
	localparam int G4_Q24      = 2318554;
	localparam int ONE_Q24     = 16777216;
	localparam int FALLOFF_Q24 = 10066330;
	localparam int NOISE_MAX   = 32767;
	localparam int NOISE_MIN   = -32768;

	typedef logic signed [VW-1:0] vec_t;
	typedef logic signed [TW-1:0] term_t;

	typedef struct packed {
		logic signed [31:0] coord_x;
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_z;
		logic signed [31:0] coord_w;
	} point_t;

	typedef struct packed {
		logic signed [NW-1:0] noise_value;
	} noise_t;

	localparam logic [7:0] HASH_ROM [256] = '{
		8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13, 8'd201, 8'd95,
		8'd96, 8'd53, 8'd194, 8'd233, 8'd7, 8'd225, 8'd140, 8'd36, 8'd103, 8'd30,
		8'd69, 8'd142, 8'd8, 8'd99, 8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190,
		8'd6, 8'd148, 8'd247, 8'd120, 8'd234, 8'd75, 8'd0, 8'd26, 8'd197, 8'd62,
		8'd94, 8'd252, 8'd219, 8'd203, 8'd117, 8'd35, 8'd11, 8'd32, 8'd57, 8'd177,
		8'd33, 8'd88, 8'd237, 8'd149, 8'd56, 8'd87, 8'd174, 8'd20, 8'd125, 8'd136,
		8'd171, 8'd168, 8'd68, 8'd175, 8'd74, 8'd165, 8'd71, 8'd134, 8'd139, 8'd48,
		8'd27, 8'd166, 8'd77, 8'd146, 8'd158, 8'd231, 8'd83, 8'd111, 8'd229, 8'd122,
		8'd60, 8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92, 8'd41, 8'd55, 8'd46,
		8'd245, 8'd40, 8'd244, 8'd102, 8'd143, 8'd54, 8'd65, 8'd25, 8'd63, 8'd161,
		8'd1, 8'd216, 8'd80, 8'd73, 8'd209, 8'd76, 8'd132, 8'd187, 8'd208, 8'd89,
		8'd18, 8'd169, 8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
		8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64, 8'd52, 8'd217,
		8'd226, 8'd250, 8'd124, 8'd123, 8'd5, 8'd202, 8'd38, 8'd147, 8'd118, 8'd126,
		8'd255, 8'd82, 8'd85, 8'd212, 8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16,
		8'd58, 8'd17, 8'd182, 8'd189, 8'd28, 8'd42, 8'd223, 8'd183, 8'd170, 8'd213,
		8'd119, 8'd248, 8'd152, 8'd2, 8'd44, 8'd154, 8'd163, 8'd70, 8'd221, 8'd153,
		8'd101, 8'd155, 8'd167, 8'd43, 8'd172, 8'd9, 8'd129, 8'd22, 8'd39, 8'd253,
		8'd19, 8'd98, 8'd108, 8'd110, 8'd79, 8'd113, 8'd224, 8'd232, 8'd178, 8'd185,
		8'd112, 8'd104, 8'd218, 8'd246, 8'd97, 8'd228, 8'd251, 8'd34, 8'd242, 8'd193,
		8'd238, 8'd210, 8'd144, 8'd12, 8'd191, 8'd179, 8'd162, 8'd241, 8'd81, 8'd51,
		8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107, 8'd49, 8'd192, 8'd214, 8'd31,
		8'd181, 8'd199, 8'd106, 8'd157, 8'd184, 8'd84, 8'd204, 8'd176, 8'd115, 8'd121,
		8'd50, 8'd45, 8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
		8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141, 8'd128, 8'd195,
		8'd78, 8'd66, 8'd215, 8'd61, 8'd156, 8'd180
	};

	// Rank of each axis, two bits per axis, x in the top pair.
	function automatic logic [7:0] rank_row(input logic [5:0] code);
		logic [7:0] row;
		unique case (code)
			6'd0:    row = 8'b00_01_10_11;
			6'd1:    row = 8'b00_01_11_10;
			6'd3:    row = 8'b00_10_11_01;
			6'd7:    row = 8'b01_10_11_00;
			6'd8:    row = 8'b00_10_01_11;
			6'd10:   row = 8'b00_11_01_10;
			6'd11:   row = 8'b00_11_10_01;
			6'd15:   row = 8'b01_11_10_00;
			6'd24:   row = 8'b01_10_00_11;
			6'd26:   row = 8'b01_11_00_10;
			6'd30:   row = 8'b10_11_00_01;
			6'd31:   row = 8'b10_11_01_00;
			6'd32:   row = 8'b01_00_10_11;
			6'd33:   row = 8'b01_00_11_10;
			6'd37:   row = 8'b10_00_11_01;
			6'd39:   row = 8'b10_01_11_00;
			6'd48:   row = 8'b10_00_01_11;
			6'd52:   row = 8'b11_00_01_10;
			6'd53:   row = 8'b11_00_10_01;
			6'd55:   row = 8'b11_01_10_00;
			6'd56:   row = 8'b10_01_00_11;
			6'd60:   row = 8'b11_01_00_10;
			6'd62:   row = 8'b11_10_00_01;
			6'd63:   row = 8'b11_10_01_00;
			default: row = 8'b00_00_00_00;
		endcase
		return row;
	endfunction

endpackage

[sv/snd4_stream_if.sv]
interface snd4_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[sv/simplex_noise_4d_top.sv]
// Channel  Dir  Payload                              Format
// point    in   coord_x, coord_y, coord_z, coord_w   signed Q16.16 each
// noise    out  noise_value                          signed Q2.14, saturated
//
// One point enters per cycle unless the output stalls.
// The depth is set by the skew multiply, the cell unskew multiply and the
// four dependent permutation lookups of each corner hash, one per stage.
// Reset clears only the stage valid bits; no state is kept between points.
// A stalled output freezes the whole pipeline, and point is ready again as
// soon as the output register is empty or being taken.
`include "simplex_noise_4d_top_defines.svh"

module simplex_noise_4d_top #(
	parameter int IN_FRAC_BITS  = 16,
	parameter int OUT_FRAC_BITS = 14
) (
	input  logic         clk,
	input  logic         arst_n,
	snd4_stream_if.sink   point,
	snd4_stream_if.source noise
);
	import snd4_pkg::*;

	logic             en;
	logic [DEPTH-1:0] stage_vld_q;
	vec_t             v_c [NCORNER][NAXIS];
	logic [NAXIS-1:0] step_c [NCORNER];
	logic [7:0]       base_c [NAXIS];
	term_t            term_c [NCORNER];
	noise_t           noise_c;

	assign en          = !stage_vld_q[DEPTH-1] || noise.ready;
	assign point.ready = en;
	assign noise.valid = stage_vld_q[DEPTH-1];
	assign noise.data  = noise_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else if (en) begin
			stage_vld_q <= {stage_vld_q[DEPTH-2:0], point.valid};
		end
	end

	snd4_lattice #(
		.IN_FRAC_BITS(IN_FRAC_BITS)
	) u_lattice (
		.clk  (clk),
		.en   (en),
		.point(point.data),
		.v    (v_c),
		.step (step_c),
		.base (base_c)
	);

	for (genvar m = 0; m < NCORNER; m++) begin : g_corner
		snd4_corner u_corner (
			.clk (clk),
			.en  (en),
			.v   (v_c[m]),
			.step(step_c[m]),
			.base(base_c),
			.term(term_c[m])
		);
	end

	snd4_accum #(
		.OUT_FRAC_BITS(OUT_FRAC_BITS)
	) u_accum (
		.clk  (clk),
		.en   (en),
		.term (term_c),
		.noise(noise_c)
	);

	`SND4_ASSERT_IMP(a_full_stall_blocks_input, noise.valid && !noise.ready, !point.ready)
	`SND4_ASSERT_NXT(a_accept_enters_pipe, point.valid && point.ready, stage_vld_q[0])
	`SND4_ASSERT_NXT(a_stall_freezes_pipe, !point.ready, $stable(stage_vld_q))
endmodule

[sv/snd4_lattice.sv]
module snd4_lattice #(
	parameter int IN_FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              en,
	input  snd4_pkg::point_t  point,
	output snd4_pkg::vec_t    v [snd4_pkg::NCORNER][snd4_pkg::NAXIS],
	output logic [snd4_pkg::NAXIS-1:0] step [snd4_pkg::NCORNER],
	output logic [7:0]        base [snd4_pkg::NAXIS]
);
	import snd4_pkg::*;

	localparam int PW  = 34 + 27;
	localparam int AW  = 35;
	localparam int RW  = 36;
	localparam int CW  = AW - IN_FRAC_BITS;
	localparam int CSW = CW + 2;
	localparam int UW  = CSW + 31;
	localparam int SW  = UW + 1;

	logic signed [31:0]     p_s1 [NAXIS];
	logic signed [33:0]     sum_s1;
	logic signed [31:0]     p_s2 [NAXIS];
	logic signed [PW-1:0]   prod_s2;
	logic signed [32:0]     skew_c;
	logic signed [AW-1:0]   a_c [NAXIS];
	logic signed [CW-1:0]   cell_c [NAXIS];
	logic signed [CW-1:0]   cell_s3 [NAXIS];
	logic signed [RW-1:0]   r_s3 [NAXIS];
	logic signed [CSW-1:0]  cellsum_s4;
	logic signed [RW-1:0]   r_s4 [NAXIS];
	logic [7:0]             base_s4 [NAXIS];
	logic signed [UW-1:0]   unskew_s5;
	logic signed [RW-1:0]   r_s5 [NAXIS];
	logic [7:0]             base_s5 [NAXIS];
	logic signed [SW-1:0]   dsum_c [NAXIS];
	logic signed [DW-1:0]   d_s6 [NAXIS];
	logic [7:0]             base_s6 [NAXIS];
	logic [5:0]             code_c;
	logic [7:0]             row_c;
	logic [1:0]             rk_c [NAXIS];
	logic                   st_c [NCORNER][NAXIS];
	vec_t                   v_s7 [NCORNER][NAXIS];
	logic [NAXIS-1:0]       step_s7 [NCORNER];
	logic [7:0]             base_s7 [NAXIS];

	always_ff @(posedge clk) begin
		if (en) begin
			p_s1[0] <= point.coord_x;
			p_s1[1] <= point.coord_y;
			p_s1[2] <= point.coord_z;
			p_s1[3] <= point.coord_w;
			sum_s1  <= 34'(point.coord_x) + 34'(point.coord_y) + 34'(point.coord_z)
				+ 34'(point.coord_w);
			p_s2    <= p_s1;
			prod_s2 <= sum_s1 * F4_Q28;
		end
	end

	// Skew by F4 and take the true floor to find the lattice cell.
	always_comb begin
		skew_c = prod_s2[PW-1:28];
		for (int q = 0; q < NAXIS; q++) begin
			a_c[q]    = AW'(p_s2[q]) + AW'(skew_c);
			cell_c[q] = a_c[q][IN_FRAC_BITS +: CW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int q = 0; q < NAXIS; q++) begin
				cell_s3[q] <= cell_c[q];
				r_s3[q]    <= RW'(p_s2[q]) - (RW'(cell_c[q]) <<< IN_FRAC_BITS);
				base_s4[q] <= cell_s3[q][7:0];
			end
			cellsum_s4 <= CSW'(cell_s3[0]) + CSW'(cell_s3[1]) + CSW'(cell_s3[2])
				+ CSW'(cell_s3[3]);
			r_s4       <= r_s3;
			unskew_s5  <= cellsum_s4 * G4_Q32;
			r_s5       <= r_s4;
			base_s5    <= base_s4;
		end
	end

	always_comb begin
		for (int q = 0; q < NAXIS; q++) begin
			dsum_c[q] = (SW'(r_s5[q]) <<< (32 - IN_FRAC_BITS)) + SW'(unskew_s5);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int q = 0; q < NAXIS; q++) begin
				d_s6[q] <= dsum_c[q][8 +: DW];
			end
			base_s6 <= base_s5;
		end
	end

	// Pairwise compares pick the traversal order; corner m steps along the
	// m axes of highest rank.
	always_comb begin
		code_c = {d_s6[0] > d_s6[1], d_s6[0] > d_s6[2], d_s6[1] > d_s6[2],
			d_s6[0] > d_s6[3], d_s6[1] > d_s6[3], d_s6[2] > d_s6[3]};
		row_c  = rank_row(code_c);
		for (int q = 0; q < NAXIS; q++) begin
			rk_c[q] = row_c[7 - 2 * q -: 2];
		end
		for (int m = 0; m < NCORNER; m++) begin
			for (int q = 0; q < NAXIS; q++) begin
				st_c[m][q] = (m != 0) && ({1'b0, rk_c[q]} >= 3'(NAXIS - m));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int m = 0; m < NCORNER; m++) begin
				for (int q = 0; q < NAXIS; q++) begin
					v_s7[m][q]    <= VW'(d_s6[q]) - (st_c[m][q] ? VW'(ONE_Q24) : VW'(0))
						+ VW'(m * G4_Q24);
					step_s7[m][q] <= st_c[m][q];
				end
			end
			base_s7 <= base_s6;
		end
	end

	assign v    = v_s7;
	assign step = step_s7;
	assign base = base_s7;
endmodule

[sv/snd4_corner.sv]
module snd4_corner (
	input  logic                       clk,
	input  logic                       en,
	input  snd4_pkg::vec_t             v [snd4_pkg::NAXIS],
	input  logic [snd4_pkg::NAXIS-1:0] step,
	input  logic [7:0]                 base [snd4_pkg::NAXIS],
	output snd4_pkg::term_t            term
);
	import snd4_pkg::*;

	logic signed [SQW-1:0]  sq_s8 [NAXIS];
	vec_t                   v_s8 [NAXIS];
	vec_t                   v_s9 [NAXIS];
	vec_t                   v_s10 [NAXIS];
	vec_t                   v_s11 [NAXIS];
	logic [NAXIS-1:0]       step_s8, step_s9, step_s10;
	logic [7:0]             base_s8 [NAXIS];
	logic [7:0]             base_s9 [NAXIS];
	logic [7:0]             base_s10 [NAXIS];
	logic [7:0]             h_s8, h_s9, h_s10, h_s11;
	logic [R2W-1:0]         r2_c;
	logic signed [FLW-1:0]  fall_c;
	logic [FW-1:0]          fall_s9;
	logic                   pos_s9, pos_s10, pos_s11, pos_s12;
	logic [2*FW-1:0]        f2p_c, f4p_c;
	logic [FW-1:0]          f2_s10, f4_s11, f4_s12;
	logic [1:0]             zero_c;
	logic [1:0]             k_c;
	logic signed [DOTW-1:0] dot_c;
	logic signed [DOTW-1:0] dot_s12;
	term_t                  term_s13;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int q = 0; q < NAXIS; q++) begin
				sq_s8[q] <= v[q] * v[q];
			end
			v_s8    <= v;
			step_s8 <= step;
			base_s8 <= base;
			h_s8    <= HASH_ROM[base[3] + {7'd0, step[3]}];
		end
	end

	always_comb begin
		r2_c = '0;
		for (int q = 0; q < NAXIS; q++) begin
			r2_c = r2_c + R2W'(sq_s8[q]);
		end
		fall_c = FLW'(FALLOFF_Q24) - FLW'(r2_c[R2W-1:FW]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fall_s9  <= fall_c[FW-1:0];
			pos_s9   <= fall_c > 0;
			v_s9     <= v_s8;
			step_s9  <= step_s8;
			base_s9  <= base_s8;
			h_s9     <= HASH_ROM[base_s8[2] + {7'd0, step_s8[2]} + h_s8];
		end
	end

	assign f2p_c = fall_s9 * fall_s9;
	assign f4p_c = f2_s10 * f2_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			f2_s10   <= f2p_c[2*FW-1:FW];
			pos_s10  <= pos_s9;
			v_s10    <= v_s9;
			step_s10 <= step_s9;
			base_s10 <= base_s9;
			h_s10    <= HASH_ROM[base_s9[1] + {7'd0, step_s9[1]} + h_s9];
			f4_s11   <= f4p_c[2*FW-1:FW];
			pos_s11  <= pos_s10;
			v_s11    <= v_s10;
			h_s11    <= HASH_ROM[base_s10[0] + {7'd0, step_s10[0]} + h_s10];
		end
	end

	// The gradient has one zero component, picked by hash bits 4:3; the other
	// three take their signs from bits 2, 1 and 0 in axis order.
	always_comb begin
		zero_c = h_s11[4:3];
		dot_c  = '0;
		k_c    = '0;
		for (int q = 0; q < NAXIS; q++) begin
			if (2'(q) != zero_c) begin
				if (h_s11[2 - k_c]) begin
					dot_c = dot_c - DOTW'(v_s11[q]);
				end else begin
					dot_c = dot_c + DOTW'(v_s11[q]);
				end
				k_c = k_c + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s12  <= dot_c;
			f4_s12   <= f4_s11;
			pos_s12  <= pos_s11;
			term_s13 <= pos_s12 ? $signed({1'b0, f4_s12}) * dot_s12 : term_t'(0);
		end
	end

	assign term = term_s13;
endmodule

[sv/snd4_accum.sv]
module snd4_accum #(
	parameter int OUT_FRAC_BITS = 14
) (
	input  logic             clk,
	input  logic             en,
	input  snd4_pkg::term_t  term [snd4_pkg::NCORNER],
	output snd4_pkg::noise_t noise
);
	import snd4_pkg::*;

	localparam int SH = 48 - OUT_FRAC_BITS;

	logic signed [ACW-1:0] acc_c;
	logic signed [SCW-1:0] scaled_c;
	logic signed [SCW-1:0] shifted_c;
	logic signed [NW-1:0]  sat_c;
	noise_t                noise_s14;

	// Times 27 as 16 + 8 + 2 + 1, then round half up and saturate.
	always_comb begin
		acc_c = '0;
		for (int m = 0; m < NCORNER; m++) begin
			acc_c = acc_c + ACW'(term[m]);
		end
		scaled_c  = (SCW'(acc_c) <<< 4) + (SCW'(acc_c) <<< 3) + (SCW'(acc_c) <<< 1)
			+ SCW'(acc_c) + (SCW'(1) <<< (SH - 1));
		shifted_c = scaled_c >>> SH;
		priority if (shifted_c > SCW'(NOISE_MAX)) begin
			sat_c = NW'(NOISE_MAX);
		end else if (shifted_c < SCW'(NOISE_MIN)) begin
			sat_c = NW'(NOISE_MIN);
		end else begin
			sat_c = shifted_c[NW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			noise_s14.noise_value <= sat_c;
		end
	end

	assign noise = noise_s14;
endmodule
